// File: src/scp_pkg.sv
// Package for the stick packet calibrator: payload types, codes and defaults.
// Used by the divider and the top level; depends on nothing.
`timescale 1ns / 1ps

package scp_pkg;

    localparam int DATA_W          = 16;
    localparam int FRAME_BYTES_DEF = 19;
    localparam int COUNT_BITS_DEF  = 16;

    localparam logic [7:0]  START_BYTE  = 8'hFF;
    localparam logic [7:0]  END_BYTE    = 8'hFE;
    localparam logic [15:0] MIN_RESET   = 16'hFFFF;

    localparam logic [4:0]  X_OFFSET_RESET = 5'd6;
    localparam logic [4:0]  Y_OFFSET_RESET = 5'd8;

    // Input word kinds.
    localparam logic [1:0] KIND_BYTE   = 2'd0;
    localparam logic [1:0] KIND_CLEAR  = 2'd1;
    localparam logic [1:0] KIND_REPORT = 2'd2;

    // Output word kinds.
    localparam logic OUT_SAMPLE = 1'b0;
    localparam logic OUT_REPORT = 1'b1;

    // Register indexes on the configuration port (byte address 4*index).
    localparam logic [1:0] REG_X_OFFSET = 2'd0;
    localparam logic [1:0] REG_Y_OFFSET = 2'd1;
    localparam logic [1:0] REG_MODE     = 2'd2;

    localparam logic MODE_RANGE  = 1'b0;
    localparam logic MODE_CENTER = 1'b1;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] rx_byte;
    } scp_in_t;

    typedef struct packed {
        logic        out_kind;
        logic [15:0] sample_x;
        logic [15:0] sample_y;
        logic [15:0] min_x;
        logic [15:0] max_x;
        logic [15:0] min_y;
        logic [15:0] max_y;
        logic [15:0] center_x;
        logic [15:0] center_y;
        logic        center_valid;
    } scp_out_t;

    // Status of the shared divider as seen by the sequencer.
    typedef struct packed {
        logic busy;
        logic done;
    } scp_div_stat_t;

endpackage

// File: src/scp_stream_if.sv
// Valid/ready stream channel carrying one payload word per handshake.
// The payload type is a parameter; the calibrator uses the types of scp_pkg.
`timescale 1ns / 1ps

interface scp_stream_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: src/scp_divider.sv
// Restoring divider, one quotient bit per cycle, shared by the X and Y means.
// Depends on scp_pkg for DATA_W and the status struct.
`timescale 1ns / 1ps

module scp_divider
    import scp_pkg::*;
#(
    parameter int COUNT_BITS = COUNT_BITS_DEF
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [DATA_W+COUNT_BITS-1:0] dividend,
    input  logic [COUNT_BITS-1:0]        divisor,
    output logic [DATA_W-1:0]            quotient,
    output scp_div_stat_t                stat
);

    localparam int CNT_W = $clog2(DATA_W);

    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic [COUNT_BITS-1:0] rem_reg, rem_next;
    logic [DATA_W-1:0]     quo_reg, quo_next;
    logic [COUNT_BITS:0]   trial;
    logic                  fits;

    // The mean never exceeds the largest sample, so the upper part of the
    // dividend is already below the divisor and only DATA_W steps are needed.
    assign trial = {rem_reg, quo_reg[DATA_W-1]};
    assign fits  = trial >= {1'b0, divisor};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = dividend[DATA_W+COUNT_BITS-1:DATA_W];
            quo_next  = dividend[DATA_W-1:0];
        end
        else if (busy_reg)
        begin
            if (fits)
            begin
                rem_next = COUNT_BITS'(trial - {1'b0, divisor});
            end
            else
            begin
                rem_next = trial[COUNT_BITS-1:0];
            end
            quo_next = {quo_reg[DATA_W-2:0], fits};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(DATA_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end

    assign quotient  = quo_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

    a_no_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> !busy_reg)
        else $error("divider started while busy");

    a_done_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !busy_reg && $past(busy_reg))
        else $error("divider done without a finished run");

    a_rem_below_divisor: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg && !start |-> rem_reg < divisor)
        else $error("divider remainder not below divisor");

endmodule

// File: src/stick_packet_calibrator.sv
// Top level of the stick packet calibrator: frame parser, statistics and report.
// Depends on scp_pkg, scp_stream_if and scp_divider.
`timescale 1ns / 1ps
//
//  Channel  Direction  Words                          Handshake
//  in_ch    sink       kind, rx_byte                  valid/ready
//  out_ch   source     sample or calibration report   valid/ready
//  APB      slave      x_offset, y_offset, mode       psel/penable, pready tied high
//
//  For a byte or clear word, its result, if any, sits in the output register the
//  cycle after it is taken.  A report with samples runs the shared divider twice,
//  during which in_ch.ready is low.
//  A new word is taken while the output register is empty or is being emptied.
//  Reset is asynchronous and active low; offsets return to 6 and 8, mode to range.

module stick_packet_calibrator
    import scp_pkg::*;
#(
    parameter int FRAME_BYTES = FRAME_BYTES_DEF,
    parameter int COUNT_BITS  = COUNT_BITS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    scp_stream_if.sink   in_ch,
    scp_stream_if.source out_ch,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int POS_W = $clog2(FRAME_BYTES);
    localparam int CMP_W = (POS_W > 6) ? POS_W : 6;
    localparam int SUM_W = DATA_W + COUNT_BITS;

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_DIV_X = 3'b010,
        S_DIV_Y = 3'b100
    } state_t;

    state_t state_reg, state_next;

    logic [4:0]            x_off_reg, y_off_reg;
    logic                  mode_reg;
    logic                  in_frame_reg, in_frame_next;
    logic [POS_W-1:0]      frame_pos_reg, frame_pos_next;
    logic [15:0]           capt_x_reg, capt_x_next, capt_y_reg, capt_y_next;
    logic [15:0]           min_x_reg, min_x_next, max_x_reg, max_x_next;
    logic [15:0]           min_y_reg, min_y_next, max_y_reg, max_y_next;
    logic [SUM_W-1:0]      sum_x_reg, sum_x_next, sum_y_reg, sum_y_next;
    logic [COUNT_BITS-1:0] total_reg, total_next;
    logic [15:0]           zero_x_reg, zero_x_next, zero_y_reg, zero_y_next;
    logic                  out_valid_reg, out_valid_next;
    scp_out_t              out_data_reg, out_data_next;

    logic                  in_ready, accept, cfg_write;
    logic [CMP_W-1:0]      cur_pos, x_off_ext, y_off_ext;
    logic [15:0]           base_x, base_y, cx, cy;
    logic                  div_start;
    logic [SUM_W-1:0]      div_dividend;
    logic [DATA_W-1:0]     div_quotient;
    scp_div_stat_t         div_stat;

    function automatic logic [15:0] grab(input logic [15:0]      word,
                                         input logic [CMP_W-1:0] pos,
                                         input logic [CMP_W-1:0] off,
                                         input logic [7:0]       b);
        logic [15:0] w;
        w = word;
        if (pos == off)
        begin
            w = {word[15:8], b};
        end
        else if (pos == CMP_W'(off + 1'b1))
        begin
            w = {b, word[7:0]};
        end
        return w;
    endfunction

    // ---------------- configuration port ----------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb
    begin
        case (paddr[3:2])
            REG_X_OFFSET: prdata = {27'd0, x_off_reg};
            REG_Y_OFFSET: prdata = {27'd0, y_off_reg};
            REG_MODE:     prdata = {31'd0, mode_reg};
            default:      prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_off_reg <= X_OFFSET_RESET;
            y_off_reg <= Y_OFFSET_RESET;
            mode_reg  <= MODE_RANGE;
        end
        else if (cfg_write)
        begin
            case (paddr[3:2])
                REG_X_OFFSET: x_off_reg <= pwdata[4:0];
                REG_Y_OFFSET: y_off_reg <= pwdata[4:0];
                REG_MODE:     mode_reg  <= pwdata[0];
                default:      ;
            endcase
        end
    end

    // ---------------- handshakes ----------------
    assign in_ready     = (state_reg == S_IDLE) && (!out_valid_reg || out_ch.ready);
    assign accept       = in_ch.valid && in_ready;
    assign in_ch.ready  = in_ready;
    assign out_ch.valid = out_valid_reg;
    assign out_ch.data  = out_data_reg;

    // A start byte opens a fresh capture at position zero.
    assign base_x    = in_frame_reg ? capt_x_reg : 16'd0;
    assign base_y    = in_frame_reg ? capt_y_reg : 16'd0;
    assign cur_pos   = in_frame_reg ? CMP_W'(frame_pos_reg) : '0;
    assign x_off_ext = CMP_W'(x_off_reg);
    assign y_off_ext = CMP_W'(y_off_reg);
    assign cx        = grab(base_x, cur_pos, x_off_ext, in_ch.data.rx_byte);
    assign cy        = grab(base_y, cur_pos, y_off_ext, in_ch.data.rx_byte);

    // ---------------- sequencer ----------------
    always_comb
    begin
        state_next     = state_reg;
        in_frame_next  = in_frame_reg;
        frame_pos_next = frame_pos_reg;
        capt_x_next    = capt_x_reg;
        capt_y_next    = capt_y_reg;
        min_x_next     = min_x_reg;
        max_x_next     = max_x_reg;
        min_y_next     = min_y_reg;
        max_y_next     = max_y_reg;
        sum_x_next     = sum_x_reg;
        sum_y_next     = sum_y_reg;
        total_next     = total_reg;
        zero_x_next    = zero_x_reg;
        zero_y_next    = zero_y_reg;
        out_valid_next = out_valid_reg && !out_ch.ready;
        out_data_next  = out_data_reg;
        div_start      = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    case (in_ch.data.kind)
                        KIND_CLEAR:
                        begin
                            min_x_next     = MIN_RESET;
                            max_x_next     = 16'd0;
                            min_y_next     = MIN_RESET;
                            max_y_next     = 16'd0;
                            sum_x_next     = '0;
                            sum_y_next     = '0;
                            total_next     = '0;
                            in_frame_next  = 1'b0;
                            frame_pos_next = '0;
                        end
                        KIND_REPORT:
                        begin
                            if (total_reg != '0)
                            begin
                                div_start  = 1'b1;
                                state_next = S_DIV_X;
                            end
                            else
                            begin
                                out_valid_next = 1'b1;
                                out_data_next  = '{OUT_REPORT, 16'd0, 16'd0,
                                                  min_x_reg, max_x_reg,
                                                  min_y_reg, max_y_reg,
                                                  zero_x_reg, zero_y_reg, 1'b0};
                            end
                        end
                        KIND_BYTE:
                        begin
                            if (!in_frame_reg)
                            begin
                                if (in_ch.data.rx_byte == START_BYTE)
                                begin
                                    in_frame_next  = 1'b1;
                                    frame_pos_next = POS_W'(1);
                                    capt_x_next    = cx;
                                    capt_y_next    = cy;
                                end
                            end
                            else
                            begin
                                capt_x_next = cx;
                                capt_y_next = cy;
                                if (frame_pos_reg != POS_W'(FRAME_BYTES - 1))
                                begin
                                    frame_pos_next = frame_pos_reg + 1'b1;
                                end
                                else
                                begin
                                    in_frame_next  = 1'b0;
                                    frame_pos_next = '0;
                                    if (in_ch.data.rx_byte == END_BYTE)
                                    begin
                                        if (mode_reg == MODE_RANGE)
                                        begin
                                            if (cx < min_x_reg) min_x_next = cx;
                                            if (cx > max_x_reg) max_x_next = cx;
                                            if (cy < min_y_reg) min_y_next = cy;
                                            if (cy > max_y_reg) max_y_next = cy;
                                        end
                                        else if (total_reg != {COUNT_BITS{1'b1}})
                                        begin
                                            sum_x_next = sum_x_reg + SUM_W'(cx);
                                            sum_y_next = sum_y_reg + SUM_W'(cy);
                                            total_next = total_reg + 1'b1;
                                        end
                                        out_valid_next = 1'b1;
                                        out_data_next  = '{OUT_SAMPLE, cx, cy,
                                                          min_x_next, max_x_next,
                                                          min_y_next, max_y_next,
                                                          zero_x_reg, zero_y_reg,
                                                          total_next != '0};
                                    end
                                end
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_DIV_X:
            begin
                if (div_stat.done)
                begin
                    zero_x_next = div_quotient;
                    div_start   = 1'b1;
                    state_next  = S_DIV_Y;
                end
            end
            S_DIV_Y:
            begin
                if (div_stat.done)
                begin
                    zero_y_next    = div_quotient;
                    out_valid_next = 1'b1;
                    out_data_next  = '{OUT_REPORT, 16'd0, 16'd0,
                                      min_x_reg, max_x_reg, min_y_reg, max_y_reg,
                                      zero_x_reg, div_quotient, 1'b1};
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // The X sum goes in with the report word, the Y sum when X has finished.
    assign div_dividend = (state_reg == S_DIV_X) ? sum_y_reg : sum_x_reg;

    scp_divider #(
        .COUNT_BITS (COUNT_BITS)
    ) u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (total_reg),
        .quotient (div_quotient),
        .stat     (div_stat)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            in_frame_reg  <= 1'b0;
            frame_pos_reg <= '0;
            capt_x_reg    <= 16'd0;
            capt_y_reg    <= 16'd0;
            min_x_reg     <= MIN_RESET;
            max_x_reg     <= 16'd0;
            min_y_reg     <= MIN_RESET;
            max_y_reg     <= 16'd0;
            sum_x_reg     <= '0;
            sum_y_reg     <= '0;
            total_reg     <= '0;
            zero_x_reg    <= 16'd0;
            zero_y_reg    <= 16'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            in_frame_reg  <= in_frame_next;
            frame_pos_reg <= frame_pos_next;
            capt_x_reg    <= capt_x_next;
            capt_y_reg    <= capt_y_next;
            min_x_reg     <= min_x_next;
            max_x_reg     <= max_x_next;
            min_y_reg     <= min_y_next;
            max_y_reg     <= max_y_next;
            sum_x_reg     <= sum_x_next;
            sum_y_reg     <= sum_y_next;
            total_reg     <= total_next;
            zero_x_reg    <= zero_x_next;
            zero_y_reg    <= zero_y_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    a_ready_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_ch.ready |-> state_reg == S_IDLE)
        else $error("input ready outside idle");

    a_no_word_during_divide: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != S_IDLE |-> !out_valid_reg)
        else $error("output word pending during divide");

    a_divider_idle: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_IDLE |-> !div_stat.busy)
        else $error("divider busy while sequencer idle");

    a_hunt_pos_zero: assert property (@(posedge clk) disable iff (!rst_n)
        !in_frame_reg |-> frame_pos_reg == '0)
        else $error("frame position set while hunting");

endmodule
